FILE: design/sldf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sldf_pkg;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_LEN   = 3'd2,
      PH_BODY  = 3'd3,
      PH_CRCH  = 3'd4,
      PH_CRCL  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_BODY    = 3'd1,
      EV_OK      = 3'd2,
      EV_CRCERR  = 3'd3,
      EV_LENERR  = 3'd4,
      EV_RESYNC  = 3'd5
   } event_type;

   localparam logic [1:0] MODE_DATA  = 2'd0;
   localparam logic [1:0] MODE_ABORT = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic CSR_FIRST_SYNC  = 1'b0;
   localparam logic CSR_SECOND_SYNC = 1'b1;

   localparam logic [7:0]  FIRST_SYNC_RESET  = 8'hAA;
   localparam logic [7:0]  SECOND_SYNC_RESET = 8'h55;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'h1021;

   localparam int CNT_W   = 32;
   localparam int TDATA_W = 200;

   typedef struct packed {
      event_type  ev;
      logic [7:0] body_byte;
      logic [6:0] body_index;
      logic [7:0] message_id;
      logic [7:0] sequence_id;
      logic [6:0] payload_length;
   } frame_res_type;

   typedef struct packed {
      logic count_byte;
      logic clear;
      logic inc_resync;
      logic inc_length_error;
      logic inc_crc_error;
      logic inc_good;
   } cnt_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0] bytes;
      logic [CNT_W-1:0] resyncs;
      logic [CNT_W-1:0] bad_lengths;
      logic [CNT_W-1:0] bad_crcs;
      logic [CNT_W-1:0] good_packets;
   } cnt_type;

   // One byte of CRC-16/CCITT, MSB first, no reflection.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: design/sldf_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module sldf_parser #(
   parameter int MAX_PAYLOAD = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [1:0]             mode,
   input  wire logic [7:0]             data_byte,
   input  wire logic [7:0]             first_sync,
   input  wire logic [7:0]             second_sync,
   output sldf_pkg::frame_res_type     res,
   output sldf_pkg::cnt_ctrl_type      cnt_ctrl
);

   localparam int         LEN_W   = $clog2(MAX_PAYLOAD + 3);
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD + 2);
   localparam logic [7:0] MIN_LEN = 8'd2;

   sldf_pkg::phase_type phase_ff, phase_in;
   logic [LEN_W-1:0]    frame_length_ff, frame_length_in;
   logic [LEN_W-1:0]    body_count_ff, body_count_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          crc_high_ff, crc_high_in;
   logic [7:0]          message_id_ff, message_id_in;
   logic [7:0]          sequence_ff, sequence_in;

   logic                is_data;
   logic                is_abort;
   logic                len_bad;
   logic [LEN_W-1:0]    count_inc;
   logic                body_done;

   assign is_data   = accept && (mode == sldf_pkg::MODE_DATA);
   assign is_abort  = accept && ((mode == sldf_pkg::MODE_ABORT) ||
                                 (mode == sldf_pkg::MODE_CLEAR));
   assign len_bad   = (data_byte < MIN_LEN) || (data_byte > MAX_LEN);
   assign count_inc = body_count_ff + LEN_W'(1);
   assign body_done = count_inc >= frame_length_ff;

   always_comb begin
      phase_in = phase_ff;
      if (is_abort) begin
         phase_in = sldf_pkg::PH_SYNC1;
      end else if (is_data) begin
         unique case (phase_ff)
            sldf_pkg::PH_SYNC1: begin
               if (data_byte == first_sync) phase_in = sldf_pkg::PH_SYNC2;
            end
            sldf_pkg::PH_SYNC2: begin
               if (data_byte == second_sync) begin
                  phase_in = sldf_pkg::PH_LEN;
               end else if (data_byte != first_sync) begin
                  phase_in = sldf_pkg::PH_SYNC1;
               end
            end
            sldf_pkg::PH_LEN: begin
               phase_in = len_bad ? sldf_pkg::PH_SYNC1 : sldf_pkg::PH_BODY;
            end
            sldf_pkg::PH_BODY: begin
               if (body_done) phase_in = sldf_pkg::PH_CRCH;
            end
            sldf_pkg::PH_CRCH: phase_in = sldf_pkg::PH_CRCL;
            sldf_pkg::PH_CRCL: phase_in = sldf_pkg::PH_SYNC1;
            default:           phase_in = sldf_pkg::PH_SYNC1;
         endcase
      end
   end

   always_comb begin
      logic wipe;
      wipe            = is_abort;
      res             = '0;
      res.ev          = sldf_pkg::EV_NONE;
      frame_length_in = frame_length_ff;
      body_count_in   = body_count_ff;
      crc_in          = crc_ff;
      crc_high_in     = crc_high_ff;
      message_id_in   = message_id_ff;
      sequence_in     = sequence_ff;
      if (is_data) begin
         unique case (phase_ff)
            sldf_pkg::PH_SYNC1: ;
            sldf_pkg::PH_SYNC2: begin
               if ((data_byte != second_sync) && (data_byte != first_sync)) begin
                  res.ev = sldf_pkg::EV_RESYNC;
               end
            end
            sldf_pkg::PH_LEN: begin
               if (len_bad) begin
                  res.ev = sldf_pkg::EV_LENERR;
                  wipe   = 1'b1;
               end else begin
                  frame_length_in = LEN_W'(data_byte);
                  body_count_in   = '0;
                  crc_in          = sldf_pkg::crc16_byte(sldf_pkg::CRC_INIT, data_byte);
               end
            end
            sldf_pkg::PH_BODY: begin
               res.ev         = sldf_pkg::EV_BODY;
               res.body_byte  = data_byte;
               res.body_index = 7'(body_count_ff);
               if (body_count_ff == '0) begin
                  message_id_in = data_byte;
               end else if (body_count_ff == LEN_W'(1)) begin
                  sequence_in = data_byte;
               end
               crc_in        = sldf_pkg::crc16_byte(crc_ff, data_byte);
               body_count_in = count_inc;
            end
            sldf_pkg::PH_CRCH: crc_high_in = data_byte;
            sldf_pkg::PH_CRCL: begin
               res.message_id     = message_id_ff;
               res.sequence_id    = sequence_ff;
               res.payload_length = 7'(frame_length_ff - LEN_W'(2));
               res.ev = ({crc_high_ff, data_byte} == crc_ff) ? sldf_pkg::EV_OK
                                                              : sldf_pkg::EV_CRCERR;
               wipe   = 1'b1;
            end
            default: wipe = 1'b1;
         endcase
      end
      if (wipe) begin
         frame_length_in = '0;
         body_count_in   = '0;
         crc_in          = sldf_pkg::CRC_INIT;
         crc_high_in     = '0;
         message_id_in   = '0;
         sequence_in     = '0;
      end
   end

   always_comb begin
      cnt_ctrl.count_byte       = is_data;
      cnt_ctrl.clear            = accept && (mode == sldf_pkg::MODE_CLEAR);
      cnt_ctrl.inc_resync       = res.ev == sldf_pkg::EV_RESYNC;
      cnt_ctrl.inc_length_error = res.ev == sldf_pkg::EV_LENERR;
      cnt_ctrl.inc_crc_error    = res.ev == sldf_pkg::EV_CRCERR;
      cnt_ctrl.inc_good         = res.ev == sldf_pkg::EV_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sldf_pkg::PH_SYNC1;
         frame_length_ff <= '0;
         body_count_ff   <= '0;
         crc_ff          <= sldf_pkg::CRC_INIT;
         crc_high_ff     <= '0;
         message_id_ff   <= '0;
         sequence_ff     <= '0;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         body_count_ff   <= body_count_in;
         crc_ff          <= crc_in;
         crc_high_ff     <= crc_high_in;
         message_id_ff   <= message_id_in;
         sequence_ff     <= sequence_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/sldf_counters.sv
`timescale 1ns / 1ps
`default_nettype none
module sldf_counters (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sldf_pkg::cnt_ctrl_type cnt_ctrl,
   output sldf_pkg::cnt_type           cnt_next
);

   sldf_pkg::cnt_type cnt_ff, cnt_in;

   always_comb begin
      if (cnt_ctrl.clear) begin
         cnt_in = '0;
      end else begin
         cnt_in.bytes        = cnt_ff.bytes + sldf_pkg::CNT_W'(cnt_ctrl.count_byte);
         cnt_in.resyncs      = cnt_ff.resyncs + sldf_pkg::CNT_W'(cnt_ctrl.inc_resync);
         cnt_in.bad_lengths  = cnt_ff.bad_lengths +
                               sldf_pkg::CNT_W'(cnt_ctrl.inc_length_error);
         cnt_in.bad_crcs     = cnt_ff.bad_crcs + sldf_pkg::CNT_W'(cnt_ctrl.inc_crc_error);
         cnt_in.good_packets = cnt_ff.good_packets + sldf_pkg::CNT_W'(cnt_ctrl.inc_good);
      end
   end

   assign cnt_next = cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/sync_length_crc_packet_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte-stream deframer: sync pair, length byte, body, big-endian CRC-16/CCITT.
// Request channel (req_*): one received byte per request, with a mode in
// tuser that selects data byte, abort frame, or abort frame and clear counters.
// Response channel (rsp_*): exactly one response per request, carrying the
// event code in tuser and the body byte, its index, the frame header fields
// and the five wrapping 32-bit counters in tdata.
// Configuration port (csr_*): index 0 writes the first sync byte, index 1 the
// second; write only while no request is in flight.
// The response is registered and is presented in the cycle after its request
// is accepted. Throughput is one request per cycle while the receiver takes
// responses, set by the combinational byte-wide CRC update and phase decode.
// When the receiver stalls, the response register holds its content and
// req_tready drops until the response is taken; a request is accepted in the
// same cycle the pending response leaves.
// Synchronous reset returns the parser to the sync hunt, clears all counters,
// empties the response register and restores the sync bytes to 0xAA and 0x55.
module sync_length_crc_packet_deframer_core #(
   parameter int MAX_PAYLOAD = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output wire logic                         req_tready,
   input  wire logic [7:0]                   req_tdata,  // data_byte
   input  wire logic [1:0]                   req_tuser,  // mode
   output wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   // body_byte, body_index, message_id_out, sequence_out, payload_length,
   // bytes_seen, resyncs_seen, length error count, checksum error count,
   // good_packets_seen, zero fill
   output wire logic [sldf_pkg::TDATA_W-1:0] rsp_tdata,
   output wire logic [2:0]                   rsp_tuser,  // event_res
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [7:0]                   csr_wdata
);

   logic                         accept;
   logic [7:0]                   first_sync_ff, first_sync_in;
   logic [7:0]                   second_sync_ff, second_sync_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sldf_pkg::TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]                   rsp_user_ff, rsp_user_in;

   sldf_pkg::frame_res_type      res;
   sldf_pkg::cnt_ctrl_type       cnt_ctrl;
   sldf_pkg::cnt_type            cnt_next;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   sldf_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_tuser),
      .data_byte   (req_tdata),
      .first_sync  (first_sync_ff),
      .second_sync (second_sync_ff),
      .res         (res),
      .cnt_ctrl    (cnt_ctrl)
   );

   sldf_counters u_counters (
      .clock    (clock),
      .reset    (reset),
      .cnt_ctrl (cnt_ctrl),
      .cnt_next (cnt_next)
   );

   always_comb begin
      first_sync_in  = first_sync_ff;
      second_sync_in = second_sync_ff;
      if (csr_we) begin
         unique case (csr_index)
            sldf_pkg::CSR_FIRST_SYNC:  first_sync_in  = csr_wdata;
            sldf_pkg::CSR_SECOND_SYNC: second_sync_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res.ev;
         rsp_data_in  = {2'b00,
                         cnt_next.good_packets, cnt_next.bad_crcs,
                         cnt_next.bad_lengths, cnt_next.resyncs, cnt_next.bytes,
                         res.payload_length, res.sequence_id, res.message_id,
                         res.body_index, res.body_byte};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= sldf_pkg::FIRST_SYNC_RESET;
         second_sync_ff <= sldf_pkg::SECOND_SYNC_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         first_sync_ff  <= first_sync_in;
         second_sync_ff <= second_sync_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_clear_zeroes_counters: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == sldf_pkg::MODE_CLEAR) |=>
         (rsp_data_ff[197:38] == '0))
      else $error("counter clear left a nonzero counter");

   a_body_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff == sldf_pkg::EV_BODY) |->
         (rsp_data_ff[14:8] < 7'(MAX_PAYLOAD + 2)))
      else $error("body index beyond the largest frame");

   a_header_only_on_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff != sldf_pkg::EV_OK) &&
         (rsp_user_ff != sldf_pkg::EV_CRCERR) |-> (rsp_data_ff[37:15] == '0))
      else $error("header fields set outside a verdict");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int MAX_PAYLOAD = 64;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data;
   } rx_request_type;

   typedef struct packed {
      sldf_pkg::event_type ev;
      logic [7:0]          body_byte;
      logic [6:0]          body_index;
      logic [7:0]          message_id;
      logic [7:0]          sequence_id;
      logic [6:0]          payload_length;
      sldf_pkg::cnt_type   counts;
   } deframe_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire logic req_tready;
   logic [7:0] req_tdata = 8'h00;  // data_byte
   logic [1:0] req_tuser = 2'd0;   // mode
   wire logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // body_byte, body_index, message_id_out, sequence_out, payload_length,
   // bytes_seen, resyncs_seen, length error count, checksum error count,
   // good_packets_seen, zero fill
   wire logic [sldf_pkg::TDATA_W-1:0] rsp_tdata;
   wire logic [2:0] rsp_tuser;     // event_res
   logic csr_we = 1'b0;
   logic csr_index = sldf_pkg::CSR_FIRST_SYNC;
   logic [7:0] csr_wdata = 8'h00;

   sync_length_crc_packet_deframer_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   rx_request_type     pending_reqs[$];
   deframe_result_type expected_results[$];
   int  requests_queued = 0;
   int  responses_seen = 0;
   int  error_count = 0;
   int  idle_pct = 15;
   int  stall_cycles = 0;
   logic req_taken = 1'b0;

   // Shadow of the deframer state and its sync byte registers.
   logic [7:0]          sync_a = sldf_pkg::FIRST_SYNC_RESET;
   logic [7:0]          sync_b = sldf_pkg::SECOND_SYNC_RESET;
   sldf_pkg::phase_type ph = sldf_pkg::PH_SYNC1;
   logic [6:0]          flen = '0;
   logic [6:0]          bcnt = '0;
   logic [15:0]         crc_acc = sldf_pkg::CRC_INIT;
   logic [7:0]          crc_hi = '0;
   logic [7:0]          msg_id = '0;
   logic [7:0]          seq_id = '0;
   sldf_pkg::cnt_type   tally = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Bitwise CRC-16/CCITT, message bits shifted in MSB first.
   function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ sldf_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   task automatic drop_frame();
      ph = sldf_pkg::PH_SYNC1;
      flen = '0;
      bcnt = '0;
      crc_acc = sldf_pkg::CRC_INIT;
      crc_hi = '0;
      msg_id = '0;
      seq_id = '0;
   endtask

   task automatic predict_request(input logic [1:0] mode, input logic [7:0] b);
      deframe_result_type r;
      r = '0;
      r.ev = sldf_pkg::EV_NONE;
      case (mode)
         sldf_pkg::MODE_ABORT: begin
            drop_frame();
         end
         sldf_pkg::MODE_CLEAR: begin
            drop_frame();
            tally = '0;
         end
         sldf_pkg::MODE_DATA: begin
            tally.bytes = tally.bytes + 1;
            case (ph)
               sldf_pkg::PH_SYNC1: begin
                  if (b == sync_a) ph = sldf_pkg::PH_SYNC2;
               end
               sldf_pkg::PH_SYNC2: begin
                  // The second sync byte wins when both registers hold the same value.
                  if (b == sync_b) begin
                     ph = sldf_pkg::PH_LEN;
                  end else if (b != sync_a) begin
                     tally.resyncs = tally.resyncs + 1;
                     r.ev = sldf_pkg::EV_RESYNC;
                     ph = sldf_pkg::PH_SYNC1;
                  end
               end
               sldf_pkg::PH_LEN: begin
                  if (b < 8'd2 || b > 8'(MAX_PAYLOAD + 2)) begin
                     tally.bad_lengths = tally.bad_lengths + 1;
                     r.ev = sldf_pkg::EV_LENERR;
                     drop_frame();
                  end else begin
                     flen = b[6:0];
                     bcnt = '0;
                     crc_acc = ccitt_update(sldf_pkg::CRC_INIT, b);
                     ph = sldf_pkg::PH_BODY;
                  end
               end
               sldf_pkg::PH_BODY: begin
                  r.ev = sldf_pkg::EV_BODY;
                  r.body_byte = b;
                  r.body_index = bcnt;
                  if (bcnt == 7'd0) begin
                     msg_id = b;
                  end else if (bcnt == 7'd1) begin
                     seq_id = b;
                  end
                  crc_acc = ccitt_update(crc_acc, b);
                  bcnt = bcnt + 7'd1;
                  if (bcnt >= flen) ph = sldf_pkg::PH_CRCH;
               end
               sldf_pkg::PH_CRCH: begin
                  crc_hi = b;
                  ph = sldf_pkg::PH_CRCL;
               end
               sldf_pkg::PH_CRCL: begin
                  r.message_id = msg_id;
                  r.sequence_id = seq_id;
                  r.payload_length = flen - 7'd2;
                  if ({crc_hi, b} == crc_acc) begin
                     tally.good_packets = tally.good_packets + 1;
                     r.ev = sldf_pkg::EV_OK;
                  end else begin
                     tally.bad_crcs = tally.bad_crcs + 1;
                     r.ev = sldf_pkg::EV_CRCERR;
                  end
                  drop_frame();
               end
               default: begin
                  drop_frame();
               end
            endcase
         end
         default: begin
         end
      endcase
      r.counts = tally;
      expected_results.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      deframe_result_type got;
      deframe_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            got.ev = sldf_pkg::event_type'(rsp_tuser);
            got.body_byte = rsp_tdata[7:0];
            got.body_index = rsp_tdata[14:8];
            got.message_id = rsp_tdata[22:15];
            got.sequence_id = rsp_tdata[30:23];
            got.payload_length = rsp_tdata[37:31];
            got.counts.bytes = rsp_tdata[69:38];
            got.counts.resyncs = rsp_tdata[101:70];
            got.counts.bad_lengths = rsp_tdata[133:102];
            got.counts.bad_crcs = rsp_tdata[165:134];
            got.counts.good_packets = rsp_tdata[197:166];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual event %0d",
                        $time, rsp_tuser);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("event_res", 32'(want.ev), 32'(got.ev));
               check_field("body_byte", 32'(want.body_byte), 32'(got.body_byte));
               check_field("body_index", 32'(want.body_index), 32'(got.body_index));
               check_field("message_id_out", 32'(want.message_id), 32'(got.message_id));
               check_field("sequence_out", 32'(want.sequence_id), 32'(got.sequence_id));
               check_field("payload_length", 32'(want.payload_length),
                           32'(got.payload_length));
               check_field("bytes_seen", want.counts.bytes, got.counts.bytes);
               check_field("resyncs_seen", want.counts.resyncs, got.counts.resyncs);
               check_field("length error count", want.counts.bad_lengths,
                           got.counts.bad_lengths);
               check_field("checksum error count", want.counts.bad_crcs,
                           got.counts.bad_crcs);
               check_field("good_packets_seen", want.counts.good_packets,
                           got.counts.good_packets);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, expected_results.size());
            $display("DONE: errors detected");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   always @(negedge clock) begin : request_driver
      rx_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            item = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= item.mode;
            req_tdata <= item.data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic send(input logic [1:0] mode, input logic [7:0] data);
      rx_request_type item;
      item.mode = mode;
      item.data = data;
      pending_reqs.push_back(item);
      requests_queued++;
   endtask

   task automatic send_frame(input logic [7:0] len, input bit corrupt, input bit extra_sync);
      logic [15:0] c;
      logic [7:0] b;
      if (extra_sync) send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, sync_b);
      send(sldf_pkg::MODE_DATA, len);
      c = ccitt_update(sldf_pkg::CRC_INIT, len);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         send(sldf_pkg::MODE_DATA, b);
         c = ccitt_update(c, b);
      end
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
      send(sldf_pkg::MODE_DATA, c[15:8]);
      send(sldf_pkg::MODE_DATA, c[7:0]);
   endtask

   // Mostly short bodies keep the run quick; the limits still come up.
   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 8'd2;
      if (r < 10) return 8'(MAX_PAYLOAD + 2);
      if (r < 80) return 8'($urandom_range(10, 2));
      return 8'($urandom_range(MAX_PAYLOAD + 1, 11));
   endfunction

   task automatic random_traffic(input int n);
      int stop_at;
      int r;
      int k;
      logic [7:0] len;
      stop_at = requests_queued + n;
      while (requests_queued < stop_at) begin
         r = $urandom_range(99);
         if (r < 62) begin
            send_frame(pick_length(), $urandom_range(99) < 20, $urandom_range(99) < 25);
         end else if (r < 72) begin
            send(sldf_pkg::MODE_DATA, sync_a);
            send(sldf_pkg::MODE_DATA, sync_b);
            k = $urandom_range(3);
            send(sldf_pkg::MODE_DATA, (k == 0) ? 8'd0 : (k == 1) ? 8'd1 :
                 (k == 2) ? 8'(MAX_PAYLOAD + 3) : 8'($urandom_range(255, MAX_PAYLOAD + 3)));
         end else if (r < 80) begin
            send(sldf_pkg::MODE_DATA, sync_a);
            send(sldf_pkg::MODE_DATA, 8'($urandom));
         end else if (r < 88) begin
            k = $urandom_range(4, 1);
            for (int i = 0; i < k; i++) send(sldf_pkg::MODE_DATA, 8'($urandom));
         end else if (r < 95) begin
            // Frame cut short somewhere in the body or checksum, then dropped.
            len = pick_length();
            send(sldf_pkg::MODE_DATA, sync_a);
            send(sldf_pkg::MODE_DATA, sync_b);
            send(sldf_pkg::MODE_DATA, len);
            k = $urandom_range(len + 1, 0);
            for (int i = 0; i < k; i++) send(sldf_pkg::MODE_DATA, 8'($urandom));
            send(($urandom_range(99) < 70) ? sldf_pkg::MODE_ABORT : sldf_pkg::MODE_CLEAR,
                 8'($urandom));
         end else begin
            k = $urandom_range(2);
            send((k == 0) ? MODE_UNUSED :
                 (k == 1) ? sldf_pkg::MODE_ABORT : sldf_pkg::MODE_CLEAR,
                 8'($urandom));
         end
      end
   endtask

   task automatic drain();
      while (responses_seen < requests_queued) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sldf_pkg::CSR_FIRST_SYNC;
      csr_wdata <= first;
      @(negedge clock);
      csr_index <= sldf_pkg::CSR_SECOND_SYNC;
      csr_wdata <= second;
      @(negedge clock);
      csr_we <= 1'b0;
      sync_a = first;
      sync_b = second;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset sync values.
      send(sldf_pkg::MODE_DATA, 8'h00);
      send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, 8'hFF);
      send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, sync_b);
      send(sldf_pkg::MODE_DATA, 8'd1);
      send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, sync_b);
      send(sldf_pkg::MODE_DATA, 8'(MAX_PAYLOAD + 3));
      send_frame(8'd2, 1'b0, 1'b0);
      send_frame(8'd2, 1'b1, 1'b0);
      send(sldf_pkg::MODE_DATA, sync_a);
      send(sldf_pkg::MODE_DATA, sync_b);
      send(sldf_pkg::MODE_DATA, 8'd4);
      send(sldf_pkg::MODE_DATA, 8'h11);
      send(sldf_pkg::MODE_ABORT, 8'hFF);
      send(sldf_pkg::MODE_CLEAR, 8'h00);
      send(MODE_UNUSED, 8'hFF);
      send(sldf_pkg::MODE_DATA, 8'hFF);
      drain();

      set_sync(8'h00, 8'hFF);
      random_traffic(145);
      drain();

      // No idling on either side through this setting.
      idle_pct = 0;
      set_sync(8'hFF, 8'h00);
      random_traffic(145);
      drain();
      idle_pct = 15;

      set_sync(8'h7E, 8'h7E);
      random_traffic(145);
      drain();

      set_sync(8'($urandom), 8'($urandom));
      random_traffic(145);
      drain();

      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time,
                  expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
